// ----- hw/rtl/assert_macros.svh -----
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked at every rising clock edge, off while reset is low.
`define ASSERT_CLK(label, clk, rst_n, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
		else $error(msg);

// Same check with a fixed clock and reset name pair.
`define ASSERT_STD(label, prop, msg) \
	`ASSERT_CLK(label, clk, arst_n, prop, msg)

`endif

// ----- hw/rtl/crpe_pkg.sv -----
package crpe_pkg;

	// Input word kinds carried in s_tuser.
	localparam logic OP_PUSH = 1'b0;
	localparam logic OP_EVAL = 1'b1;

	localparam int COORD_W   = 16;
	localparam int T_BITS    = 16;
	localparam int GUARD     = 8;
	localparam int COEF_W    = 20;
	localparam int H_W       = 30;
	localparam int PROD_W    = H_W + T_BITS + 1;
	localparam int NUM_AXES  = 3;
	localparam int WIN_DEPTH = 4;
	localparam int STEP_W    = 4;
	localparam int CNT_W     = 3;

	localparam logic [1:0] AXIS_LAST = 2'd2;

	typedef logic signed [COORD_W-1:0] coord_t;

	// Coefficient select codes.
	localparam logic [1:0] COEF_D3 = 2'd0;
	localparam logic [1:0] COEF_D2 = 2'd1;
	localparam logic [1:0] COEF_D1 = 2'd2;
	localparam logic [1:0] COEF_C0 = 2'd3;

	// One microcode word.
	typedef struct packed {
		logic              load_h;
		logic              mul;
		logic              acc;
		logic [1:0]        coef_sel;
		logic              store;
		logic              loop;
		logic              done;
		logic [STEP_W-1:0] target;
	} ctrl_word_t;

	localparam ctrl_word_t CW_NOP = '{load_h: 1'b0, mul: 1'b0, acc: 1'b0,
		coef_sel: COEF_D3, store: 1'b0, loop: 1'b0, done: 1'b0, target: '0};

	// Program: per axis load d3, three multiply/accumulate pairs, store and loop.
	function automatic ctrl_word_t ucode_rom(input logic [STEP_W-1:0] step);
		ctrl_word_t cw;
		cw = CW_NOP;
		case (step)
			4'd0: begin
				cw.load_h   = 1'b1;
				cw.coef_sel = COEF_D3;
			end
			4'd1: cw.mul = 1'b1;
			4'd2: begin
				cw.acc      = 1'b1;
				cw.coef_sel = COEF_D2;
			end
			4'd3: cw.mul = 1'b1;
			4'd4: begin
				cw.acc      = 1'b1;
				cw.coef_sel = COEF_D1;
			end
			4'd5: cw.mul = 1'b1;
			4'd6: begin
				cw.acc      = 1'b1;
				cw.coef_sel = COEF_C0;
			end
			4'd7: begin
				cw.store  = 1'b1;
				cw.loop   = 1'b1;
				cw.target = 4'd0;
			end
			4'd8: cw.done = 1'b1;
			default: cw = CW_NOP;
		endcase
		return cw;
	endfunction

endpackage

// ----- hw/rtl/crpe_axis_dp.sv -----
module crpe_axis_dp (
	input  logic                 clk,
	input  crpe_pkg::ctrl_word_t ctrl,
	input  crpe_pkg::coord_t     p0,
	input  crpe_pkg::coord_t     p1,
	input  crpe_pkg::coord_t     p2,
	input  crpe_pkg::coord_t     p3,
	input  logic [15:0]          t,
	output crpe_pkg::coord_t     res,
	output logic                 clip
);
	import crpe_pkg::*;

	logic signed [COEF_W-1:0] e0, e1, e2, e3;
	logic signed [COEF_W-1:0] d1, d2, d3, c0x2, coef;
	logic signed [H_W-1:0]    coef_g, rnd, h_q, final_sum;
	logic signed [PROD_W-1:0] prod_q, prod_rnd;
	logic signed [H_W-GUARD-2:0] r;

	// Twice the spline coefficients, exact integers.
	assign e0   = COEF_W'(p0);
	assign e1   = COEF_W'(p1);
	assign e2   = COEF_W'(p2);
	assign e3   = COEF_W'(p3);
	assign d1   = e2 - e0;
	assign d2   = (e0 <<< 1) - (e1 <<< 2) - e1 + (e2 <<< 2) - e3;
	assign d3   = e1 + (e1 <<< 1) - e0 - e2 - (e2 <<< 1) + e3;
	assign c0x2 = e1 <<< 1;

	always_comb begin
		case (ctrl.coef_sel)
			COEF_D3: coef = d3;
			COEF_D2: coef = d2;
			COEF_D1: coef = d1;
			COEF_C0: coef = c0x2;
			default: coef = d3;
		endcase
	end

	assign coef_g = H_W'(coef) <<< GUARD;

	// Product divided by 2^16, rounded half up.
	assign prod_rnd = prod_q + PROD_W'(1 << (T_BITS - 1));
	assign rnd      = prod_rnd[T_BITS +: H_W];

	// Horner accumulator and the shared multiplier.
	always_ff @(posedge clk) begin
		if (ctrl.load_h) begin
			h_q <= coef_g;
		end else if (ctrl.acc) begin
			h_q <= coef_g + rnd;
		end
		if (ctrl.mul) begin
			prod_q <= h_q * $signed({1'b0, t});
		end
	end

	// Final rounding by the guard bits and the factor two, then clipping.
	assign final_sum = h_q + H_W'(1 << GUARD);
	assign r         = final_sum[H_W-1:GUARD+1];

	always_comb begin
		clip = 1'b0;
		if (r > $signed((H_W-GUARD-1)'(32767))) begin
			res  = 16'sh7FFF;
			clip = 1'b1;
		end else if (r < $signed(-(H_W-GUARD-1)'(32768))) begin
			res  = 16'sh8000;
			clip = 1'b1;
		end else begin
			res = r[COORD_W-1:0];
		end
	end

endmodule

// ----- hw/rtl/catmull_rom_point_evaluator_unit.sv -----
// Channel | Dir | Fields (low bit first)
// s_*     | in  | tdata: point_x, point_y, point_z, param_t; tuser: opcode
// m_*     | out | tdata: curve_x, curve_y, curve_z; tuser: window_full, saturated
//
// A push word is taken without holding the input and gives no result.
// An evaluate word runs the microcode: 8 steps per axis on the shared multiplier,
// plus one step to hand over the result.
// s_tready is low while an evaluation runs; a result waiting on m_tready does
// not block the input, but the next evaluation holds in its last step until
// the output register is free. Reset clears the point window and the push count.
module catmull_rom_point_evaluator_unit (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [63:0] s_tdata,  // point_x, point_y, point_z, param_t
	input  logic        s_tuser,  // opcode
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [47:0] m_tdata,  // curve_x, curve_y, curve_z
	output logic [1:0]  m_tuser   // window_full, saturated
);
	import crpe_pkg::*;

	coord_t            win_q [WIN_DEPTH][NUM_AXES];
	logic [CNT_W-1:0]  pushed_q;
	logic              busy_q;
	logic [STEP_W-1:0] step_q;
	logic [1:0]        axis_q;
	logic [15:0]       t_q;
	coord_t            acc_res_q [NUM_AXES];
	logic              sat_q;
	coord_t            out_q [NUM_AXES];
	logic              out_full_q;
	logic              out_sat_q;
	logic              m_tvalid_q;
	ctrl_word_t        cw;
	coord_t            dp_res;
	logic              dp_clip;
	logic              in_acc;
	logic              out_free;

	assign s_tready = !busy_q;
	assign in_acc   = s_tvalid && s_tready;
	assign out_free = !m_tvalid_q || m_tready;
	assign cw       = busy_q ? ucode_rom(step_q) : CW_NOP;

	// Point window and push count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < WIN_DEPTH; i++) begin
				for (int a = 0; a < NUM_AXES; a++) begin
					win_q[i][a] <= '0;
				end
			end
			pushed_q <= '0;
		end else if (in_acc && s_tuser == OP_PUSH) begin
			for (int i = 0; i < WIN_DEPTH - 1; i++) begin
				win_q[i] <= win_q[i+1];
			end
			win_q[WIN_DEPTH-1][0] <= s_tdata[15:0];
			win_q[WIN_DEPTH-1][1] <= s_tdata[31:16];
			win_q[WIN_DEPTH-1][2] <= s_tdata[47:32];
			if (pushed_q < CNT_W'(WIN_DEPTH)) begin
				pushed_q <= pushed_q + 1'b1;
			end
		end
	end

	// Microcode sequencer: step counter, axis loop and hand-over.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			step_q <= '0;
			axis_q <= '0;
		end else if (!busy_q) begin
			if (in_acc && s_tuser == OP_EVAL) begin
				busy_q <= 1'b1;
				step_q <= '0;
				axis_q <= '0;
			end
		end else if (cw.loop) begin
			if (axis_q != AXIS_LAST) begin
				axis_q <= axis_q + 1'b1;
				step_q <= cw.target;
			end else begin
				step_q <= step_q + 1'b1;
			end
		end else if (cw.done) begin
			if (out_free) begin
				busy_q <= 1'b0;
			end
		end else begin
			step_q <= step_q + 1'b1;
		end
	end

	// Parameter latch and per-axis results of the running evaluation.
	always_ff @(posedge clk) begin
		if (in_acc && s_tuser == OP_EVAL) begin
			t_q   <= s_tdata[63:48];
			sat_q <= 1'b0;
		end else if (cw.store) begin
			acc_res_q[axis_q] <= dp_res;
			sat_q             <= sat_q | dp_clip;
		end
	end

	crpe_axis_dp u_dp (
		.clk  (clk),
		.ctrl (cw),
		.p0   (win_q[0][axis_q]),
		.p1   (win_q[1][axis_q]),
		.p2   (win_q[2][axis_q]),
		.p3   (win_q[3][axis_q]),
		.t    (t_q),
		.res  (dp_res),
		.clip (dp_clip)
	);

	// Output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (cw.done && out_free) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cw.done && out_free) begin
			out_q      <= acc_res_q;
			out_full_q <= (pushed_q >= CNT_W'(WIN_DEPTH));
			out_sat_q  <= sat_q;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = {out_q[2], out_q[1], out_q[0]};
	assign m_tuser  = {out_sat_q, out_full_q};

endmodule

// ----- hw/rtl/crpe_checker.sv -----
`include "assert_macros.svh"

module crpe_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        s_tvalid,
	input logic        s_tready,
	input logic        s_tuser,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [47:0] m_tdata,
	input logic [1:0]  m_tuser
);
	import crpe_pkg::*;

	logic s_acc;
	logic m_stall;

	// Handshake terms shared by the checks below.
	assign s_acc   = s_tvalid && s_tready;
	assign m_stall = m_tvalid && !m_tready;

	// A stalled result word holds its valid and payload.
	`ASSERT_STD(a_out_hold, m_stall |=> m_tvalid && $stable({m_tuser, m_tdata}), "stalled word changed")

	// An evaluate word makes the block busy on the next cycle.
	`ASSERT_STD(a_eval_busy, s_acc && s_tuser == OP_EVAL |=> !s_tready, "ready after evaluate word")

	// A push word completes at once and leaves the input ready.
	`ASSERT_STD(a_push_ready, s_acc && s_tuser == OP_PUSH |=> s_tready, "not ready after push word")

	// A push word never brings a new result in the next cycle.
	`ASSERT_STD(a_push_no_res, s_acc && s_tuser == OP_PUSH && !m_tvalid |=> !m_tvalid, "result after push")

endmodule

bind catmull_rom_point_evaluator_unit crpe_checker u_crpe_checker (.*);
